// ===== rtl/stmpd_pkg.sv =====
// shared types, codes and helpers of the st map point distortion block
// no dependencies; imported by every module of the block
`default_nettype none

package stmpd_pkg;

  localparam int FRAC         = 8;
  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 256;
  localparam int DW           = 24;   // divisor magnitude width
  localparam int QW           = 47;   // dividend and quotient magnitude width
  localparam int SATW         = 64;

  localparam logic signed [SATW-1:0] OUT_MAX = 8388607;
  localparam logic signed [SATW-1:0] OUT_MIN = -8388608;

  typedef enum logic [1:0] {
    KIND_WR_DIRECT,
    KIND_WR_INVERSE,
    KIND_ADD,
    KIND_REMOVE
  } kind_t;

  typedef enum logic [1:0] {
    ST_INTERP,
    ST_PASS,
    ST_OFFMAP,
    ST_DIVZ
  } status_t;

  // item fields that ride along the divider
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] s;
    logic [15:0] t;
    logic        dz;
    logic        neg_x;
    logic        neg_y;
  } div_side_t;

  // point item fields that ride along the blend
  typedef struct packed {
    status_t            status;
    logic signed [23:0] fb_x;
    logic signed [23:0] fb_y;
    logic [FRAC-1:0]    fx;
    logic [FRAC-1:0]    fy;
  } pt_side_t;

  function automatic logic signed [23:0] sat24(input logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] c;
    c = v;
    if (c > OUT_MAX) c = OUT_MAX;
    if (c < OUT_MIN) c = OUT_MIN;
    return c[23:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/st_map_point_distortion.sv =====
// throughput one item per cycle while the output is not stalled; the 47-stage
// quotient pipeline sets the depth, the four banked map memories give all four
// neighbours each cycle; a stalled output freezes the whole pipe
// synchronous active-low reset clears the valid bits and resets the configuration
// registers to defaults; map contents are undefined until written, no clearing pass
`default_nettype none

module st_map_point_distortion #(
  parameter int MAX_MAP_COLS = stmpd_pkg::MAX_COLS_DEF,
  parameter int MAX_MAP_ROWS = stmpd_pkg::MAX_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_map_row,
  input  logic [7:0]         in_map_col,
  input  logic [15:0]        in_map_s,
  input  logic [15:0]        in_map_t,
  input  logic signed [23:0] in_point_x,
  input  logic signed [23:0] in_point_y,
  input  logic signed [23:0] in_point_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic signed [23:0] out_w,
  output logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import stmpd_pkg::*;

  typedef enum logic [2:0] {
    REG_FOCAL,
    REG_CX,
    REG_CY,
    REG_COLS,
    REG_ROWS,
    REG_READY
  } reg_idx_t;

  localparam int CW  = $clog2(MAX_MAP_COLS);
  localparam int RW  = $clog2(MAX_MAP_ROWS);
  localparam int CLW = $clog2(MAX_MAP_COLS + 1);
  localparam int RLW = $clog2(MAX_MAP_ROWS + 1);
  localparam int UW  = 52;
  localparam logic signed [UW-1:0] HALF_PX = 1 << (FRAC - 1);
  localparam logic signed [UW-1:0] ONE     = 1;

  // configuration
  logic signed [23:0] focal_r, cx_r, cy_r;
  logic [8:0]         cols_r, rows_r;
  logic               ready_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= 24'sd256;
      cx_r    <= '0;
      cy_r    <= '0;
      cols_r  <= 9'd256;
      rows_r  <= 9'd256;
      ready_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FOCAL: focal_r <= pwdata[23:0];
        REG_CX:    cx_r    <= pwdata[23:0];
        REG_CY:    cy_r    <= pwdata[23:0];
        REG_COLS:  cols_r  <= pwdata[8:0];
        REG_ROWS:  rows_r  <= pwdata[8:0];
        REG_READY: ready_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FOCAL: prdata = {8'b0, focal_r};
      REG_CX:    prdata = {8'b0, cx_r};
      REG_CY:    prdata = {8'b0, cy_r};
      REG_COLS:  prdata = {23'b0, cols_r};
      REG_ROWS:  prdata = {23'b0, rows_r};
      REG_READY: prdata = {31'b0, ready_r};
      default:   prdata = '0;
    endcase
  end

  // map size clamped to 1..max
  logic [CLW-1:0]       cols_c;
  logic [RLW-1:0]       rows_c;
  logic signed [UW-1:0] cols_s, rows_s;

  always_comb begin
    if (cols_r == '0) cols_c = CLW'(1);
    else if (32'(cols_r) > MAX_MAP_COLS) cols_c = CLW'(MAX_MAP_COLS);
    else cols_c = CLW'(cols_r);
    if (rows_r == '0) rows_c = RLW'(1);
    else if (32'(rows_r) > MAX_MAP_ROWS) rows_c = RLW'(MAX_MAP_ROWS);
    else rows_c = RLW'(rows_r);
    cols_s = $signed(UW'(cols_c));
    rows_s = $signed(UW'(rows_c));
  end

  // s0: input register
  logic               v0_r;
  kind_t              k0_r;
  logic [7:0]         row0_r, col0_r;
  logic [15:0]        s0_r, t0_r;
  logic signed [23:0] px0_r, py0_r, pz0_r;

  // s1: products
  logic                v1_r;
  div_side_t           side1_r;
  logic signed [47:0]  prx1_r, pry1_r;
  logic signed [23:0]  pz1_r;

  // s2: magnitudes into the divider
  logic                v2_r;
  div_side_t           side2_r;
  logic [QW-1:0]       ax2_r, ay2_r;
  logic [DW-1:0]       ad2_r;

  logic                dv_vld;
  logic [QW-1:0]       dq_x, dq_y;
  div_side_t           dside;

  // s3: signed image point
  logic                v3_r;
  div_side_t           side3_r;
  logic signed [47:0]  xi3_r, yi3_r;

  // s4: shifted point
  logic                v4_r;
  div_side_t           side4_r;
  logic signed [UW-1:0] ux4_r, uy4_r;
  logic signed [23:0]  fbx4_r, fby4_r;

  // s5: map access
  logic                v5_r;
  logic                pt5_r;
  logic                wr5_r;
  logic                sel5_r;
  logic [7:0]          row5_r, col5_r;
  logic [31:0]         dat5_r;
  logic [RW-1:0]       ny5_r;
  logic [CW-1:0]       nx5_r;
  pt_side_t            ps5_r;

  // s6: neighbours available
  logic                v6_r;
  pt_side_t            ps6_r;
  logic [3:0][31:0]    nb6;

  logic                bl_vld;
  pt_side_t            bl_side;
  logic signed [23:0]  bl_x, bl_y;

  logic                out_valid_r;
  logic signed [23:0]  out_x_r, out_y_r, out_w_r;
  status_t             out_status_r;

  logic adv;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= dv_vld;
      v4_r <= v3_r;
      v5_r <= v4_r;
      // only point items go on to give a result item
      v6_r <= v5_r && pt5_r;
      out_valid_r <= bl_vld;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [UW-1:0] nxw, nyw;
    logic                 off;
    logic                 pt;
    div_side_t            s2;
    if (adv) begin
      k0_r   <= kind_t'(in_kind);
      row0_r <= in_map_row;
      col0_r <= in_map_col;
      s0_r   <= in_map_s;
      t0_r   <= in_map_t;
      px0_r  <= in_point_x;
      py0_r  <= in_point_y;
      pz0_r  <= in_point_z;

      prx1_r        <= focal_r * px0_r;
      pry1_r        <= focal_r * py0_r;
      pz1_r         <= pz0_r;
      side1_r.kind  <= k0_r;
      side1_r.row   <= row0_r;
      side1_r.col   <= col0_r;
      side1_r.s     <= s0_r;
      side1_r.t     <= t0_r;
      side1_r.dz    <= (pz0_r == '0) || (focal_r == '0);
      side1_r.neg_x <= 1'b0;
      side1_r.neg_y <= 1'b0;

      s2       = side1_r;
      s2.neg_x = prx1_r[47] ^ pz1_r[23];
      s2.neg_y = pry1_r[47] ^ pz1_r[23];
      side2_r <= s2;
      ax2_r <= prx1_r[47] ? QW'(-prx1_r) : QW'(prx1_r);
      ay2_r <= pry1_r[47] ? QW'(-pry1_r) : QW'(pry1_r);
      ad2_r <= pz1_r[23] ? DW'(-pz1_r) : DW'(pz1_r);

      side3_r <= dside;
      xi3_r   <= dside.neg_x ? -$signed({1'b0, dq_x}) : $signed({1'b0, dq_x});
      yi3_r   <= dside.neg_y ? -$signed({1'b0, dq_y}) : $signed({1'b0, dq_y});

      side4_r <= side3_r;
      ux4_r   <= UW'(xi3_r) + (cols_s <<< (FRAC - 1)) - UW'(cx_r) - HALF_PX;
      uy4_r   <= UW'(yi3_r) + (rows_s <<< (FRAC - 1)) - UW'(cy_r) - HALF_PX;
      fbx4_r  <= sat24(SATW'(xi3_r));
      fby4_r  <= sat24(SATW'(yi3_r));

      // neighbour search and fallback selection
      nxw = ux4_r >>> FRAC;
      nyw = uy4_r >>> FRAC;
      off = ux4_r[UW-1] || (nxw >= cols_s - ONE) || uy4_r[UW-1] || (nyw >= rows_s - ONE);
      pt  = (side4_r.kind == KIND_ADD) || (side4_r.kind == KIND_REMOVE);
      pt5_r  <= pt;
      wr5_r  <= v4_r && !pt && (32'(side4_r.row) < MAX_MAP_ROWS) &&
                (32'(side4_r.col) < MAX_MAP_COLS);
      sel5_r <= (side4_r.kind == KIND_WR_INVERSE) || (side4_r.kind == KIND_REMOVE);
      row5_r <= side4_r.row;
      col5_r <= side4_r.col;
      dat5_r <= {side4_r.t, side4_r.s};
      nx5_r  <= nxw[CW-1:0];
      ny5_r  <= nyw[RW-1:0];
      ps5_r.fx <= ux4_r[FRAC-1:0];
      ps5_r.fy <= uy4_r[FRAC-1:0];
      if (side4_r.dz) begin
        ps5_r.status <= ST_DIVZ;
        ps5_r.fb_x   <= '0;
        ps5_r.fb_y   <= '0;
      end else begin
        ps5_r.fb_x   <= fbx4_r;
        ps5_r.fb_y   <= fby4_r;
        if (!ready_r) ps5_r.status <= ST_PASS;
        else if (off) ps5_r.status <= ST_OFFMAP;
        else ps5_r.status <= ST_INTERP;
      end

      ps6_r <= ps5_r;

      out_w_r      <= focal_r;
      out_status_r <= bl_side.status;
      if (bl_side.status == ST_INTERP) begin
        out_x_r <= bl_x;
        out_y_r <= bl_y;
      end else begin
        out_x_r <= bl_side.fb_x;
        out_y_r <= bl_side.fb_y;
      end
    end
  end

  stmpd_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (v2_r),
    .num_x  (ax2_r),
    .num_y  (ay2_r),
    .den    (ad2_r),
    .side_i (side2_r),
    .out_vld(dv_vld),
    .q_x    (dq_x),
    .q_y    (dq_y),
    .side_o (dside)
  );

  stmpd_map #(
    .MAX_MAP_COLS(MAX_MAP_COLS),
    .MAX_MAP_ROWS(MAX_MAP_ROWS)
  ) u_map (
    .clk    (clk),
    .adv    (adv),
    .wr_en  (wr5_r),
    .sel    (sel5_r),
    .wr_row (row5_r),
    .wr_col (col5_r),
    .wr_data(dat5_r),
    .rd_row (ny5_r),
    .rd_col (nx5_r),
    .nb     (nb6)
  );

  stmpd_blend u_blend (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .cx     (cx_r),
    .cy     (cy_r),
    .in_vld (v6_r),
    .side_i (ps6_r),
    .nb     (nb6),
    .out_vld(bl_vld),
    .side_o (bl_side),
    .res_x  (bl_x),
    .res_y  (bl_y)
  );

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_w      = out_w_r;
  assign out_status = out_status_r;

`ifndef SYNTH
  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_DIVZ)) |-> (out_x == '0) && (out_y == '0))
    else $error("division by zero item carries a nonzero point");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(v0_r) && $stable(v6_r) && $stable(out_x_r))
    else $error("pipeline moved while stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/stmpd_div.sv =====
// pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage
// depends on stmpd_pkg
`default_nettype none

module stmpd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_vld,
  input  logic [stmpd_pkg::QW-1:0]    num_x,
  input  logic [stmpd_pkg::QW-1:0]    num_y,
  input  logic [stmpd_pkg::DW-1:0]    den,
  input  stmpd_pkg::div_side_t        side_i,
  output logic                        out_vld,
  output logic [stmpd_pkg::QW-1:0]    q_x,
  output logic [stmpd_pkg::QW-1:0]    q_y,
  output stmpd_pkg::div_side_t        side_o
);
  import stmpd_pkg::*;

  logic            vld_r  [QW];
  logic [DW-1:0]   den_r  [QW];
  div_side_t       side_r [QW];
  logic [DW-1:0]   rem_r  [QW][2];
  logic [QW-1:0]   dq_r   [QW][2];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          p_vld;
    logic [DW-1:0] p_den;
    div_side_t     p_side;
    logic [DW-1:0] p_rem [2];
    logic [QW-1:0] p_dq  [2];
    logic [DW:0]   trial [2];
    logic          ge    [2];

    if (i == 0) begin : g_first
      always_comb begin
        p_vld    = in_vld;
        p_den    = den;
        p_side   = side_i;
        p_rem[0] = '0;
        p_rem[1] = '0;
        p_dq[0]  = num_x;
        p_dq[1]  = num_y;
      end
    end else begin : g_next
      always_comb begin
        p_vld    = vld_r[i-1];
        p_den    = den_r[i-1];
        p_side   = side_r[i-1];
        p_rem[0] = rem_r[i-1][0];
        p_rem[1] = rem_r[i-1][1];
        p_dq[0]  = dq_r[i-1][0];
        p_dq[1]  = dq_r[i-1][1];
      end
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {p_rem[l], p_dq[l][QW-1]};
        ge[l]    = trial[l] >= {1'b0, p_den};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[i]  <= p_den;
        side_r[i] <= p_side;
        for (int l = 0; l < 2; l++) begin
          rem_r[i][l] <= ge[l] ? DW'(trial[l] - {1'b0, p_den}) : DW'(trial[l]);
          dq_r[i][l]  <= {p_dq[l][QW-2:0], ge[l]};
        end
      end
    end
  end

  assign out_vld = vld_r[QW-1];
  assign q_x     = dq_r[QW-1][0];
  assign q_y     = dq_r[QW-1][1];
  assign side_o  = side_r[QW-1];

endmodule

`default_nettype wire

// ===== rtl/stmpd_map.sv =====
// both st maps, split into four banks by row and column parity so that the
// 2x2 neighbours are read in the same cycle; depends on stmpd_pkg
`default_nettype none

module stmpd_map #(
  parameter int MAX_MAP_COLS = stmpd_pkg::MAX_COLS_DEF,
  parameter int MAX_MAP_ROWS = stmpd_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              adv,
  input  logic                              wr_en,
  input  logic                              sel,
  input  logic [7:0]                        wr_row,
  input  logic [7:0]                        wr_col,
  input  logic [31:0]                       wr_data,
  input  logic [$clog2(MAX_MAP_ROWS)-1:0]   rd_row,
  input  logic [$clog2(MAX_MAP_COLS)-1:0]   rd_col,
  output logic [3:0][31:0]                  nb
);
  import stmpd_pkg::*;

  localparam int HCW   = ($clog2((MAX_MAP_COLS + 1) / 2) > 0) ?
                         $clog2((MAX_MAP_COLS + 1) / 2) : 1;
  localparam int HRW   = ($clog2((MAX_MAP_ROWS + 1) / 2) > 0) ?
                         $clog2((MAX_MAP_ROWS + 1) / 2) : 1;
  localparam int AW    = 1 + HRW + HCW;
  localparam int DEPTH = 1 << AW;

  logic [31:0] rd_r [4];
  logic        rpar_r;
  logic        cpar_r;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam int RP = b / 2;
    localparam int CP = b % 2;
    logic [31:0]    mem [DEPTH];
    logic [HRW-1:0] hr;
    logic [HCW-1:0] hc;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic           wr_hit;

    // odd bank holds index>>1, even bank the next even index at or above
    always_comb begin
      hr = (RP == 1) ? HRW'(rd_row >> 1) : HRW'(rd_row >> 1) + HRW'(rd_row[0]);
      hc = (CP == 1) ? HCW'(rd_col >> 1) : HCW'(rd_col >> 1) + HCW'(rd_col[0]);
      rd_addr = {sel, hr, hc};
      wr_addr = {sel, HRW'(wr_row >> 1), HCW'(wr_col >> 1)};
      wr_hit  = wr_en && (wr_row[0] == 1'(RP)) && (wr_col[0] == 1'(CP));
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (wr_hit) mem[wr_addr] <= wr_data;
        rd_r[b] <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rpar_r <= rd_row[0];
      cpar_r <= rd_col[0];
    end
  end

  // neighbour {k,l} sits in the bank of parity {row^k, col^l}
  always_comb begin
    logic [1:0] bi;
    for (int n = 0; n < 4; n++) begin
      bi    = {rpar_r ^ 1'(n / 2), cpar_r ^ 1'(n % 2)};
      nb[n] = rd_r[bi];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stmpd_blend.sv =====
// bilinear weights, weighted sums of s and t, scaling by twice the centre and
// floor division by 65535*2^frac; depends on stmpd_pkg
`default_nettype none

module stmpd_blend (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic signed [23:0]       cx,
  input  logic signed [23:0]       cy,
  input  logic                     in_vld,
  input  stmpd_pkg::pt_side_t      side_i,
  input  logic [3:0][31:0]         nb,
  output logic                     out_vld,
  output stmpd_pkg::pt_side_t      side_o,
  output logic signed [23:0]       res_x,
  output logic signed [23:0]       res_y
);
  import stmpd_pkg::*;

  localparam int NST = 7;
  localparam int WW  = 2 * FRAC + 1;
  localparam int PW  = WW + 16;
  localparam int AW  = PW + 2;
  localparam int SQW = AW - FRAC;
  localparam int NW  = SQW + 27;

  localparam logic signed [NW-1:0] HALF_D = 65535 * (1 << (FRAC - 1));
  localparam logic signed [NW-1:0] M16    = 65535;
  localparam logic signed [NW-1:0] ONE    = 1;

  logic            vld_r  [NST];
  pt_side_t        side_r [NST];

  logic [WW-1:0]          w_r   [4];
  logic [31:0]            nb_r  [4];
  logic [PW-1:0]          p_r   [2][4];
  logic [SQW-1:0]         sq_r  [2];
  logic signed [NW-1:0]   n_r   [2];
  logic signed [NW-1:0]   q1_r  [2];
  logic signed [NW-1:0]   y1_r  [2];
  logic signed [NW-1:0]   qs_r  [2];
  logic signed [NW-1:0]   y2_r  [2];
  logic signed [23:0]     res_r [2];

  logic [FRAC:0]          wx [2];
  logic [FRAC:0]          wy [2];
  logic signed [23:0]     c  [2];

  always_comb begin
    wx[0] = (FRAC+1)'(1 << FRAC) - (FRAC+1)'(side_i.fx);
    wx[1] = (FRAC+1)'(side_i.fx);
    wy[0] = (FRAC+1)'(1 << FRAC) - (FRAC+1)'(side_i.fy);
    wy[1] = (FRAC+1)'(side_i.fy);
    c[0]  = cx;
    c[1]  = cy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < NST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [AW-1:0]        acc;
    logic signed [NW-1:0] xs;
    logic signed [NW-1:0] q;
    logic signed [NW-1:0] y3;
    logic signed [NW-1:0] corr;
    if (adv) begin
      side_r[0] <= side_i;
      for (int i = 1; i < NST; i++) side_r[i] <= side_r[i-1];

      // weights
      for (int n = 0; n < 4; n++) begin
        w_r[n]  <= WW'(WW'(wy[n / 2]) * WW'(wx[n % 2]));
        nb_r[n] <= nb[n];
      end

      for (int l = 0; l < 2; l++) begin
        // weighted entries, lane 0 takes s, lane 1 takes t
        for (int n = 0; n < 4; n++) begin
          p_r[l][n] <= PW'(w_r[n]) * PW'(nb_r[n][16*l +: 16]);
        end

        acc = AW'(p_r[l][0]) + AW'(p_r[l][1]) + AW'(p_r[l][2]) + AW'(p_r[l][3]);
        sq_r[l] <= SQW'((acc + AW'(1 << (FRAC - 1))) >> FRAC);

        n_r[l] <= ((NW'(c[l]) * $signed(NW'(sq_r[l]))) <<< 1) + HALF_D;

        // floor by 65535: fold the high half back onto the low half
        xs = n_r[l] >>> FRAC;
        q  = xs >>> 16;
        q1_r[l] <= q;
        y1_r[l] <= q + $signed(NW'(xs[15:0]));

        q = y1_r[l] >>> 16;
        qs_r[l] <= q1_r[l] + q;
        y2_r[l] <= q + $signed(NW'(y1_r[l][15:0]));

        q  = y2_r[l] >>> 16;
        y3 = q + $signed(NW'(y2_r[l][15:0]));
        if (y3 < 0) corr = -ONE;
        else if (y3 >= M16) corr = ONE;
        else corr = '0;
        res_r[l] <= sat24(SATW'(qs_r[l] + q + corr));
      end
    end
  end

  assign out_vld = vld_r[NST-1];
  assign side_o  = side_r[NST-1];
  assign res_x   = res_r[0];
  assign res_y   = res_r[1];

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench of the st map point distortion block
// depends on rtl/stmpd_pkg.sv and rtl/st_map_point_distortion.sv
// predicts each point item from its own map copy and compares result items in order
`default_nettype none

import stmpd_pkg::*;

typedef struct {
  logic signed [23:0] x;
  logic signed [23:0] y;
  logic signed [23:0] w;
  status_t            st;
} point_result_t;

class distortion_scoreboard;
  logic signed [23:0] zh, cx, cy;
  logic [8:0]         cols_r, rows_r;
  bit                 ready;
  bit [31:0]          st_map [2][65536];
  bit                 loaded [2][65536];
  point_result_t      expected_q[$];
  int                 holes[$];
  int                 mismatches, results_seen;
  int                 per_status[4];

  function new();
    zh = 256; cx = 0; cy = 0; cols_r = 256; rows_r = 256; ready = 0;
  endfunction

  function void set_reg(int idx, logic [31:0] v);
    case (idx)
      0: zh = v[23:0];
      1: cx = v[23:0];
      2: cy = v[23:0];
      3: cols_r = v[8:0];
      4: rows_r = v[8:0];
      5: ready = v[0];
      default: ;
    endcase
  endfunction

  function longint floor_div(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function logic signed [23:0] clip24(longint v);
    if (v > 64'sd8388607) v = 8388607;
    if (v < -64'sd8388608) v = -8388608;
    return v[23:0];
  endfunction

  function longint map_cols();
    return (cols_r < 1) ? 1 : (cols_r > 256) ? 256 : cols_r;
  endfunction

  function longint map_rows();
    return (rows_r < 1) ? 1 : (rows_r > 256) ? 256 : rows_r;
  endfunction

  // classifies a point and gives its image point, neighbour and fraction
  function status_t place(longint px, longint py, longint pz, output longint xi,
                          output longint yi, output longint nx, output longint ny,
                          output longint fx, output longint fy);
    longint zv, ux, uy;
    zv = zh;
    xi = 0; yi = 0; nx = 0; ny = 0; fx = 0; fy = 0;
    if (pz == 0 || zv == 0) return ST_DIVZ;
    xi = (zv * px) / pz;
    yi = (zv * py) / pz;
    if (!ready) return ST_PASS;
    ux = xi + map_cols() * 128 - longint'(cx) - 128;
    uy = yi + map_rows() * 128 - longint'(cy) - 128;
    nx = floor_div(ux, 256);
    ny = floor_div(uy, 256);
    fx = ux - nx * 256;
    fy = uy - ny * 256;
    if (nx < 0 || nx + 1 >= map_cols() || ny < 0 || ny + 1 >= map_rows()) return ST_OFFMAP;
    return ST_INTERP;
  endfunction

  // entries a point would read that were never loaded, left in holes
  function void find_holes(kind_t k, longint px, longint py, longint pz);
    longint xi, yi, nx, ny, fx, fy;
    int m, idx;
    holes.delete();
    m = (k == KIND_ADD) ? 0 : 1;
    if (place(px, py, pz, xi, yi, nx, ny, fx, fy) != ST_INTERP) return;
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 2; c++) begin
        idx = int'((ny + r) * 256 + nx + c);
        if (!loaded[m][idx]) holes.push_back(idx);
      end
  endfunction

  function void note_input(kind_t k, logic [7:0] row, logic [7:0] col, logic [15:0] s,
                           logic [15:0] t, longint px, longint py, longint pz);
    point_result_t e;
    longint xi, yi, nx, ny, fx, fy, acc_s, acc_t, wgt, dv;
    bit [31:0] ent;
    int m;
    if (k == KIND_WR_DIRECT || k == KIND_WR_INVERSE) begin
      m = (k == KIND_WR_DIRECT) ? 0 : 1;
      st_map[m][{row, col}] = {t, s};
      loaded[m][{row, col}] = 1;
      return;
    end
    m = (k == KIND_ADD) ? 0 : 1;
    e.w = zh;
    e.st = place(px, py, pz, xi, yi, nx, ny, fx, fy);
    e.x = clip24(xi);
    e.y = clip24(yi);
    if (e.st == ST_INTERP) begin
      acc_s = 0; acc_t = 0;
      for (int r = 0; r < 2; r++)
        for (int c = 0; c < 2; c++) begin
          ent = st_map[m][int'((ny + r) * 256 + nx + c)];
          wgt = (c ? fx : 256 - fx) * (r ? fy : 256 - fy);
          acc_s += wgt * ent[15:0];
          acc_t += wgt * ent[31:16];
        end
      dv = 65535 * 256;
      e.x = clip24(floor_div(2 * longint'(cx) * ((acc_s + 128) >>> 8) + dv / 2, dv));
      e.y = clip24(floor_div(2 * longint'(cy) * ((acc_t + 128) >>> 8) + dv / 2, dv));
    end
    expected_q.push_back(e);
  endfunction

  function void check_result(logic signed [23:0] x, logic signed [23:0] y,
                             logic signed [23:0] w, logic [1:0] st);
    point_result_t e;
    results_seen++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item x=%0d y=%0d w=%0d status=%0d",
                                     x, y, w, st);
      return;
    end
    e = expected_q.pop_front();
    per_status[e.st]++;
    if (x !== e.x || y !== e.y || w !== e.w || st !== e.st) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected x=%0d y=%0d w=%0d status=%s, got x=%0d y=%0d w=%0d status=%0d",
                 e.x, e.y, e.w, e.st.name(), x, y, w, st);
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 80;
  localparam int REG_FOCAL = 0, REG_CX = 1, REG_CY = 2, REG_COLS = 3, REG_ROWS = 4,
                 REG_READY = 5;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  logic [1:0] in_kind = 0;
  logic [7:0] in_map_row = 0, in_map_col = 0;
  logic [15:0] in_map_s = 0, in_map_t = 0;
  logic signed [23:0] in_point_x = 0, in_point_y = 0, in_point_z = 0;
  logic out_valid, out_stall = 0;
  logic signed [23:0] out_x, out_y, out_w;
  logic [1:0] out_status;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;

  distortion_scoreboard sb = new();
  bit calm = 0, hold_req = 0;
  int hold_left = 0, cycles = 0, points_sent = 0, writes_sent = 0;

  st_map_point_distortion i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall, one long hold-off when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 16);
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_result(out_x, out_y, out_w, out_status);

  task automatic send_item(kind_t k, logic [7:0] row, logic [7:0] col, logic [15:0] s,
                           logic [15:0] t, logic signed [23:0] px, logic signed [23:0] py,
                           logic signed [23:0] pz);
    if (!calm && $urandom_range(0, 99) < 16) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1;
    in_kind <= k;
    in_map_row <= row;
    in_map_col <= col;
    in_map_s <= s;
    in_map_t <= t;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(k, row, col, s, t, px, py, pz);
    if (k == KIND_ADD || k == KIND_REMOVE) points_sent++;
    else writes_sent++;
    @(negedge clk);
  endtask

  // loads any map entry the point would read that was never loaded, before sending the point
  task automatic send_point(kind_t k, logic signed [23:0] px, logic signed [23:0] py,
                            logic signed [23:0] pz);
    int hq[$];
    sb.find_holes(k, px, py, pz);
    hq = sb.holes;
    foreach (hq[i])
      send_item(k == KIND_ADD ? KIND_WR_DIRECT : KIND_WR_INVERSE, hq[i][15:8], hq[i][7:0],
                $urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0, 0);
    send_point_raw(k, px, py, pz);
  endtask

  task automatic send_point_raw(kind_t k, logic signed [23:0] px, logic signed [23:0] py,
                                logic signed [23:0] pz);
    send_item(k, $urandom, $urandom, $urandom, $urandom, px, py, pz);
  endtask

  task automatic reg_write(int idx, logic [31:0] v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= idx * 4;
    pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic settle();
    in_valid <= 0;
    @(negedge clk);
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  task automatic configure(logic [23:0] zh, logic [23:0] cx, logic [23:0] cy,
                           logic [8:0] cols, logic [8:0] rows, bit rdy);
    settle();
    reg_write(REG_FOCAL, zh);
    reg_write(REG_CX, cx);
    reg_write(REG_CY, cy);
    reg_write(REG_COLS, cols);
    reg_write(REG_ROWS, rows);
    reg_write(REG_READY, rdy);
  endtask

  function automatic logic signed [23:0] fit24(longint v);
    if (v > 8388607) return 24'sh7fffff;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // point aimed at the map: z equals the focal height (256 if that is zero), so a nonzero focal height gives x itself
  task automatic send_aimed(kind_t k);
    longint c, r, ux, uy;
    logic signed [23:0] pz;
    c = sb.map_cols();
    r = sb.map_rows();
    ux = longint'($urandom_range(0, c * 256 + 127)) - 64;
    uy = longint'($urandom_range(0, r * 256 + 127)) - 64;
    pz = (sb.zh == 0) ? 24'sd256 : sb.zh;
    send_point(k, fit24(ux + sb.cx - c * 128 + 128), fit24(uy + sb.cy - r * 128 + 128), pz);
  endtask

  task automatic send_random_item();
    int pick;
    kind_t k;
    logic signed [23:0] pz;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, 1) ? KIND_ADD : KIND_REMOVE;
    if (pick < 15)
      send_item($urandom_range(0, 1) ? KIND_WR_DIRECT : KIND_WR_INVERSE, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom);
    else if (pick < 70)
      send_aimed(k);
    else if (pick < 88)
      send_point(k, $urandom, $urandom, $urandom);
    else begin
      case ($urandom_range(0, 3))
        0: pz = 0;
        1: pz = 1;
        2: pz = -1;
        default: pz = $urandom_range(1, 255);
      endcase
      send_point(k, $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000, $urandom, pz);
    end
  endtask

  initial begin
    logic [23:0] zh_v, cx_v, cy_v;
    logic [8:0] cols_v, rows_v;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: maps absent, division by zero, saturation, signs
    send_point(KIND_ADD, 0, 0, 256);
    send_point(KIND_REMOVE, 512, -512, 0);
    send_point(KIND_ADD, 24'sh7fffff, 24'sh800000, 1);
    send_point(KIND_REMOVE, -1, 1, -1);
    send_point(KIND_ADD, 24'sh7fffff, 24'sh7fffff, 24'sh800000);
    send_item(KIND_WR_DIRECT, 255, 255, 16'hffff, 16'hffff, 0, 0, 0);
    send_item(KIND_WR_INVERSE, 0, 0, 0, 0, 0, 0, 0);
    configure(0, 0, 0, 256, 256, 1);
    send_point(KIND_ADD, 100, 100, 256);
    configure(256, 256, 256, 3, 2, 1);
    send_point(KIND_ADD, 0, 0, 256);
    send_point(KIND_REMOVE, 64, -64, 256);
    send_point(KIND_ADD, 5000, 0, 256);
    send_point(KIND_REMOVE, -200, 0, 256);
    configure(24'h7fffff, 24'h7fffff, 24'h800000, 256, 256, 1);
    send_point(KIND_ADD, 0, 0, 24'h7fffff);
    send_aimed(KIND_REMOVE);
    configure(24'h800000, 0, 0, 0, 511, 1);
    send_point(KIND_ADD, 1, 1, 1);
    send_aimed(KIND_ADD);

    // random phases
    for (int ph = 0; ph < 9; ph++) begin
      case ($urandom_range(0, 3))
        0: zh_v = 256;
        1: zh_v = $urandom_range(1, 4096);
        2: zh_v = $urandom;
        default: zh_v = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      endcase
      cx_v = (ph == 4) ? 24'h7fffff : 24'($signed($urandom_range(0, 65535)) - 32768);
      cy_v = (ph == 4) ? 24'h800000 : 24'($signed($urandom_range(0, 65535)) - 32768);
      cols_v = (ph == 2) ? 9'd256 : (ph == 6) ? 9'd511 : (ph == 7) ? 9'd2 : $urandom_range(1, 12);
      rows_v = (ph == 2) ? 9'd256 : (ph == 6) ? 9'd0 : (ph == 7) ? 9'd2 : $urandom_range(1, 12);
      configure(zh_v, cx_v, cy_v, cols_v, rows_v, ph != 3);
      for (int n = 0; n < 170; n++) begin
        calm = (ph == 5 && n >= 20 && n < 150);
        if (ph == 1 && n == 30) hold_req = 1;
        send_random_item();
      end
      calm = 0;
    end

    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d point items and %0d map writes; %0d results checked",
             points_sent, writes_sent, sb.results_seen);
    $display("status mix: interpolated %0d, passthrough %0d, off map %0d, div by zero %0d",
             sb.per_status[ST_INTERP], sb.per_status[ST_PASS], sb.per_status[ST_OFFMAP],
             sb.per_status[ST_DIVZ]);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

`default_nettype wire
